>>> sv/encoder_frame_crc_position_tracker_defines.svh
// assertion macros shared by the encoder frame tracker modules
// expects a clock named clock and a reset named reset in the using module
`ifndef ENCODER_FRAME_CRC_POSITION_TRACKER_DEFINES_SVH
`define ENCODER_FRAME_CRC_POSITION_TRACKER_DEFINES_SVH

// checked only outside reset
`define EFCPT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("efcpt check failed");

// checked at every edge, reset included
`define EFCPT_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("efcpt check failed");

`endif

>>> sv/efcpt_pkg.sv
// types, constants and the crc column function of the encoder frame tracker
// no dependencies
package efcpt_pkg;

   localparam int unsigned FRAME_W    = 24;
   localparam int unsigned ANGLE_W    = 14;
   localparam int unsigned CRC_W      = 6;
   localparam int unsigned CRC_DATA_W = 18;
   localparam int unsigned TOP_DATA_BIT = 17;
   localparam int unsigned CNT_W      = 32;
   localparam int unsigned THR_W      = 8;
   localparam int unsigned DIFF_W     = 16;

   localparam logic [CRC_W-1:0] CRC_POLY = 6'h03;

   localparam logic signed [DIFF_W-1:0] HALF_TURN = 16'sd8192;
   localparam logic signed [DIFF_W-1:0] FULL_TURN = 16'sd16384;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd20;

   // register index decoded from csr address bit 2
   localparam logic REG_FAIL_TRIP_THRESHOLD = 1'b0;

   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 144;

   typedef struct packed {
      logic                    crc_good;
      logic                    trip_fault;
      logic signed [CNT_W-1:0] position;
      logic [ANGLE_W-1:0]      raw_angle;
      logic [CNT_W-1:0]        ok_count;
      logic [CNT_W-1:0]        fail_count;
      logic [CNT_W-1:0]        fail_run;
   } rsp_type;

   // crc contribution of a single set data bit, msb first, init zero
   function automatic logic [CRC_W-1:0] crc6_column(input int unsigned pos);
      logic [CRC_W-1:0] crc;
      logic             fb;
      crc = '0;
      for (int i = TOP_DATA_BIT; i >= 0; i--) begin
         fb  = (i == int'(pos)) ^ crc[CRC_W-1];
         crc = {crc[CRC_W-2:0], 1'b0};
         if (fb) begin
            crc = crc ^ CRC_POLY;
         end
      end
      return crc;
   endfunction

endpackage

>>> sv/efcpt_crc6.sv
// crc-6 check of the upper 18 frame bits against the received 6-bit crc
// depends on efcpt_pkg
module efcpt_crc6 (
   input  logic [efcpt_pkg::CRC_DATA_W-1:0] data,
   input  logic [efcpt_pkg::CRC_W-1:0]      crc_rx,
   output logic                             good
);
   import efcpt_pkg::*;

   logic [CRC_W-1:0] crc_calc;

   // crc is linear: xor of the columns of the set data bits
   always_comb begin
      crc_calc = '0;
      for (int i = 0; i < CRC_DATA_W; i++) begin
         if (data[i]) begin
            crc_calc = crc_calc ^ crc6_column(i);
         end
      end
   end

   assign good = (crc_calc == crc_rx);

endmodule

>>> sv/efcpt_track.sv
// tracker state: counters, previous angle and unwrapped position
// depends on efcpt_pkg, efcpt_crc6 and the assertion header
`include "encoder_frame_crc_position_tracker_defines.svh"

module efcpt_track (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire,
   input  logic [efcpt_pkg::FRAME_W-1:0]    frame,
   input  logic                             armed,
   input  logic [efcpt_pkg::THR_W-1:0]      threshold,
   output efcpt_pkg::rsp_type               result
);
   import efcpt_pkg::*;

   logic [ANGLE_W-1:0]      prev_angle_ff, prev_angle_in;
   logic                    have_prev_ff, have_prev_in;
   logic [CNT_W-1:0]        position_ff, position_in;
   logic [CNT_W-1:0]        good_total_ff, good_total_in;
   logic [CNT_W-1:0]        bad_total_ff, bad_total_in;
   logic [CNT_W-1:0]        bad_run_ff, bad_run_in;

   logic                    good;
   logic [ANGLE_W-1:0]      angle;
   logic signed [DIFF_W-1:0] diff;
   logic signed [DIFF_W-1:0] step;
   logic [CNT_W-1:0]        run_inc;

   assign angle = frame[FRAME_W-1 -: ANGLE_W];

   efcpt_crc6 u_crc (
      .data   (frame[FRAME_W-1 -: CRC_DATA_W]),
      .crc_rx (frame[CRC_W-1:0]),
      .good   (good)
   );

   assign run_inc = bad_run_ff + CNT_W'(1);

   // shortest signed difference; exactly a half turn keeps its sign
   always_comb begin
      diff = $signed({{(DIFF_W-ANGLE_W){1'b0}}, angle})
           - $signed({{(DIFF_W-ANGLE_W){1'b0}}, prev_angle_ff});
      step = diff;
      if (diff > HALF_TURN) begin
         step = diff - FULL_TURN;
      end else if (diff < -HALF_TURN) begin
         step = diff + FULL_TURN;
      end
   end

   always_comb begin
      prev_angle_in = prev_angle_ff;
      have_prev_in  = have_prev_ff;
      position_in   = position_ff;
      good_total_in = good_total_ff;
      bad_total_in  = bad_total_ff;
      bad_run_in    = bad_run_ff;
      if (good) begin
         good_total_in = good_total_ff + CNT_W'(1);
         bad_run_in    = '0;
         prev_angle_in = angle;
         have_prev_in  = 1'b1;
         if (have_prev_ff) begin
            position_in = position_ff + CNT_W'(unsigned'({{(CNT_W-DIFF_W){step[DIFF_W-1]}}, step}));
         end else begin
            position_in = {{(CNT_W-ANGLE_W){1'b0}}, angle};
         end
      end else begin
         bad_total_in = bad_total_ff + CNT_W'(1);
         bad_run_in   = run_inc;
      end
   end

   always_comb begin
      result.crc_good   = good;
      result.trip_fault = !good && armed && (run_inc >= {{(CNT_W-THR_W){1'b0}}, threshold});
      result.position   = position_in;
      result.raw_angle  = angle;
      result.ok_count   = good_total_in;
      result.fail_count = bad_total_in;
      result.fail_run   = bad_run_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_angle_ff <= '0;
         have_prev_ff  <= 1'b0;
         position_ff   <= '0;
         good_total_ff <= '0;
         bad_total_ff  <= '0;
         bad_run_ff    <= '0;
      end else if (fire) begin
         prev_angle_ff <= prev_angle_in;
         have_prev_ff  <= have_prev_in;
         position_ff   <= position_in;
         good_total_ff <= good_total_in;
         bad_total_ff  <= bad_total_in;
         bad_run_ff    <= bad_run_in;
      end
   end

   `EFCPT_ASSERT(a_good_clears_run, fire && good |=> bad_run_ff == '0)
   `EFCPT_ASSERT(a_bad_counts, fire && !good |=> bad_total_ff == $past(bad_total_ff) + CNT_W'(1))
   `EFCPT_ASSERT(a_no_prev_no_pos, !have_prev_ff |-> position_ff == '0)

endmodule

>>> sv/encoder_frame_crc_position_tracker.sv
// path: an accepted item passes the input register, then the result register, to rsp_tvalid
// throughput: one item per cycle unless stalled; crc check and unwrap add lie between the registers
// a stalled result register holds the input register, which fills before req_tready drops
// reset: synchronous; clears counters, position and valids, threshold returns to 20
// depends on efcpt_pkg, efcpt_track and the assertion header
`include "encoder_frame_crc_position_tracker_defines.svh"

module encoder_frame_crc_position_tracker (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata: frame [23:0], armed [24], zero [31:25]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [efcpt_pkg::REQ_DATA_W-1:0]   req_tdata,
   // rsp_tdata: crc_good [0], trip_fault [1], position [33:2], raw_angle [47:34],
   // ok_count [79:48], fail_count [111:80], fail_run [143:112]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [efcpt_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [2:0]                         csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import efcpt_pkg::*;

   logic               in_valid_ff, in_valid_in;
   logic [FRAME_W-1:0] in_frame_ff;
   logic               in_armed_ff;
   logic               out_valid_ff, out_valid_in;
   rsp_type            out_res_ff;
   rsp_type            result;
   logic [THR_W-1:0]   threshold_ff, threshold_in;
   logic               adv;
   logic               take;
   logic               csr_write;

   assign adv        = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || adv;
   assign take       = req_tvalid && req_tready;

   assign in_valid_in  = take || (in_valid_ff && !adv);
   assign out_valid_in = adv || (out_valid_ff && !rsp_tready);

   efcpt_track u_track (
      .clock     (clock),
      .reset     (reset),
      .fire      (adv),
      .frame     (in_frame_ff),
      .armed     (in_armed_ff),
      .threshold (threshold_ff),
      .result    (result)
   );

   // config port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      threshold_in = threshold_ff;
      if (csr_write && (csr_paddr[2] == REG_FAIL_TRIP_THRESHOLD)) begin
         threshold_in = csr_pwdata[THR_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_FAIL_TRIP_THRESHOLD) ?
                       {{(32-THR_W){1'b0}}, threshold_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         threshold_ff <= threshold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_frame_ff <= req_tdata[FRAME_W-1:0];
         in_armed_ff <= req_tdata[FRAME_W];
      end
      if (adv) begin
         out_res_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_res_ff.fail_run,
                        out_res_ff.fail_count,
                        out_res_ff.ok_count,
                        out_res_ff.raw_angle,
                        out_res_ff.position,
                        out_res_ff.trip_fault,
                        out_res_ff.crc_good};

   `EFCPT_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_tvalid)
   `EFCPT_ASSERT(a_adv_fills_out, adv |=> out_valid_ff)
   `EFCPT_ASSERT(a_trip_only_bad, out_valid_ff && out_res_ff.trip_fault |-> !out_res_ff.crc_good)

endmodule
